/* hdl/modular_exponentiation_assert.svh */
// Assertion macros shared by the modular exponentiation modules.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MODEXP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("modexp assertion failed");
`define MODEXP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("modexp assertion failed");
`else
`define MODEXP_ASSERT_IMP(lbl, ante, cons)
`define MODEXP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hdl/modexp_pkg.sv */
// Shared constants and types of the modular exponentiation block.
package modexp_pkg;

	localparam int OPW = 31;
	localparam int CNT_W = 5;
	localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RED  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_SQR  = 4'b1000
	} state_t;

endpackage

/* hdl/modexp_mulser.sv */
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
`include "modular_exponentiation_assert.svh"

module modexp_mulser #(
	parameter int MOD_BITS = 31
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [MOD_BITS-1:0]         a,
	input  logic [modexp_pkg::OPW-1:0]  b,
	input  logic [MOD_BITS-1:0]         m,
	output logic                        done,
	output logic [MOD_BITS-1:0]         p
);

	logic                         run_q;
	logic                         done_q;
	logic [modexp_pkg::CNT_W-1:0] cnt_q;
	logic [modexp_pkg::OPW-1:0]   b_q;
	logic [MOD_BITS-1:0]          a_q;
	logic [MOD_BITS-1:0]          r_q;
	logic [MOD_BITS:0]            dbl;
	logic [MOD_BITS:0]            dbl_sub;
	logic [MOD_BITS-1:0]          dbl_red;
	logic [MOD_BITS:0]            sum;
	logic [MOD_BITS:0]            sum_sub;
	logic [MOD_BITS-1:0]          sum_red;
	logic [MOD_BITS-1:0]          r_next;

	always_comb begin
		dbl = {r_q, 1'b0};
		dbl_sub = dbl - {1'b0, m};
		dbl_red = (dbl >= {1'b0, m}) ? dbl_sub[MOD_BITS-1:0] : dbl[MOD_BITS-1:0];
		sum = {1'b0, dbl_red} + {1'b0, a_q};
		sum_sub = sum - {1'b0, m};
		sum_red = (sum >= {1'b0, m}) ? sum_sub[MOD_BITS-1:0] : sum[MOD_BITS-1:0];
		r_next = b_q[modexp_pkg::OPW-1] ? sum_red : dbl_red;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= modexp_pkg::CNT_W'(modexp_pkg::OPW);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == modexp_pkg::CNT_W'(1)) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (run_q) begin
			b_q <= {b_q[modexp_pkg::OPW-2:0], 1'b0};
			r_q <= r_next;
		end
	end

	assign done = done_q;
	assign p = r_q;

	`MODEXP_ASSERT_IMP(a_run_cnt, run_q, cnt_q != '0)
	`MODEXP_ASSERT_IMP(a_prod_range, done_q, r_q < m)

endmodule

/* hdl/modular_exponentiation.sv */
// Top level of the modular exponentiation block (right-to-left square-and-multiply).
// A zero base or a modulus below 2 gives the done strobe in the cycle after an accepted start;
// otherwise done follows the reduction of the base and the serial multiplications and squarings.
// One item at a time; busy stays high until the last serial multiplication has finished.
// Reset clears the sequencer and the strobe and sets the modulus to 1000000007.
`include "modular_exponentiation_assert.svh"

module modular_exponentiation #(
	parameter int EXP_BITS = 63,
	parameter int MOD_BITS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [30:0] base,
	input  logic [62:0] exponent,
	output logic        done,
	output logic [30:0] result,
	input  logic        modulus_valid,
	output logic        modulus_ready,
	input  logic [30:0] modulus
);

	modexp_pkg::state_t state_q;
	modexp_pkg::state_t state_d;
	logic [30:0]                modulus_q;
	logic                       done_q;
	logic [30:0]                result_q;
	logic [EXP_BITS-1:0]        e_q;
	logic [EXP_BITS-1:0]        e_d;
	logic [EXP_BITS-1:0]        e_sh;
	logic [MOD_BITS-1:0]        acc_q;
	logic [MOD_BITS-1:0]        sq_q;
	logic [MOD_BITS-1:0]        m_q;
	logic [MOD_BITS-1:0]        m_cfg;
	logic                       accept;
	logic                       trivial;
	logic                       mul_start;
	logic [MOD_BITS-1:0]        mul_a;
	logic [modexp_pkg::OPW-1:0] mul_b;
	logic                       mul_done;
	logic [MOD_BITS-1:0]        mul_p;
	logic                       fin;
	logic [MOD_BITS-1:0]        fin_val;
	logic                       ld_acc;
	logic                       ld_sq;

	assign busy = (state_q != modexp_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign m_cfg = modulus_q[MOD_BITS-1:0];
	assign trivial = (base == '0) || (m_cfg[MOD_BITS-1:1] == '0);
	assign e_sh = e_q >> 1;
	assign modulus_ready = !busy;

	always_comb begin
		state_d = state_q;
		e_d = e_q;
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		fin = 1'b0;
		fin_val = acc_q;
		ld_acc = 1'b0;
		ld_sq = 1'b0;
		case (state_q)
			modexp_pkg::ST_IDLE: begin
				if (accept && !trivial) begin
					mul_start = 1'b1;
					mul_a = MOD_BITS'(1);
					mul_b = base;
					e_d = exponent[EXP_BITS-1:0];
					state_d = modexp_pkg::ST_RED;
				end
			end
			modexp_pkg::ST_RED: begin
				if (mul_done) begin
					ld_sq = 1'b1;
					if (e_q == '0) begin
						fin = 1'b1;
						state_d = modexp_pkg::ST_IDLE;
					end else if (e_q[0]) begin
						mul_start = 1'b1;
						mul_a = mul_p;
						mul_b = modexp_pkg::OPW'(acc_q);
						state_d = modexp_pkg::ST_MUL;
					end else begin
						mul_start = 1'b1;
						mul_a = mul_p;
						mul_b = modexp_pkg::OPW'(mul_p);
						e_d = e_sh;
						state_d = modexp_pkg::ST_SQR;
					end
				end
			end
			modexp_pkg::ST_MUL: begin
				if (mul_done) begin
					ld_acc = 1'b1;
					if (e_sh == '0) begin
						fin = 1'b1;
						fin_val = mul_p;
						state_d = modexp_pkg::ST_IDLE;
					end else begin
						mul_start = 1'b1;
						mul_a = sq_q;
						mul_b = modexp_pkg::OPW'(sq_q);
						e_d = e_sh;
						state_d = modexp_pkg::ST_SQR;
					end
				end
			end
			modexp_pkg::ST_SQR: begin
				if (mul_done) begin
					ld_sq = 1'b1;
					mul_start = 1'b1;
					mul_a = mul_p;
					if (e_q[0]) begin
						mul_b = modexp_pkg::OPW'(acc_q);
						state_d = modexp_pkg::ST_MUL;
					end else begin
						mul_b = modexp_pkg::OPW'(mul_p);
						e_d = e_sh;
						state_d = modexp_pkg::ST_SQR;
					end
				end
			end
			default: begin
				state_d = modexp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= modexp_pkg::ST_IDLE;
			done_q <= 1'b0;
			modulus_q <= modexp_pkg::MODULUS_RESET;
		end else begin
			state_q <= state_d;
			done_q <= fin || (accept && trivial);
			if (modulus_valid && modulus_ready) begin
				modulus_q <= modulus;
			end
		end
	end

	always_ff @(posedge clk) begin
		e_q <= e_d;
		if (fin) begin
			result_q <= 31'(fin_val);
		end else if (accept && trivial) begin
			result_q <= '0;
		end
		if (accept) begin
			acc_q <= MOD_BITS'(1);
			m_q <= m_cfg;
		end else if (ld_acc) begin
			acc_q <= mul_p;
		end
		if (ld_sq) begin
			sq_q <= mul_p;
		end
	end

	modexp_mulser #(
		.MOD_BITS(MOD_BITS)
	) u_mulser (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.m      (m_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign done = done_q;
	assign result = result_q;

	`MODEXP_ASSERT_IMP(a_mul_done_busy, mul_done, busy)
	`MODEXP_ASSERT_NXT(a_accept_resp, start && !busy, done || busy)
	`MODEXP_ASSERT_IMP(a_result_range, done && $past(busy), result < 31'(m_q))

endmodule
